@@ src/wsd_pkg.sv @@
// Shared types and codes for the WebSocket frame deframer.
// Used by wsd_in_stage, wsd_parser and websocket_frame_deframer; no dependencies.
package wsd_pkg;

  typedef enum logic [3:0] {
    OP_TEXT   = 4'd1,
    OP_BINARY = 4'd2,
    OP_CLOSE  = 4'd8,
    OP_PING   = 4'd9
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PING   = 3'd1,
    EV_CLOSE  = 3'd2,
    EV_SHORT  = 3'd3,
    EV_TRUNC  = 3'd4,
    EV_UNHAND = 3'd5
  } event_t;

  localparam logic [6:0] LEN16_CODE = 7'd126;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic [2:0] event_res;
    logic [3:0] frame_opcode;
  } result_t;

endpackage

@@ src/websocket_frame_deframer.sv @@
// WebSocket frame deframer, receive side: top level with the result register.
// Depends on wsd_pkg, wsd_in_stage and wsd_parser.
//
// Usage: received bytes enter one word at a time on the in_ channel, with
// in_end_of_buffer set on the last byte of each received buffer; each buffer
// carries one frame. The out_ channel gives zero or one word per input word:
// an unmasked text or binary payload byte (the last one marked), an event
// (ping or close reply request, short header, truncated payload, unhandled
// opcode), or both on the same word. Bytes after the end of a frame give no
// word until the end of the buffer.
// A word taken into the input register is parsed and lands in the result
// register when it advances. Throughput is one word per cycle while the
// receiver keeps up, set by the single parse step between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; in_ready falls only when both are full.
// While the result is stalled the parser waits, whether or not the next word
// gives a result.
// Reset clears the valid flags of both registers and returns the parser to the first header byte.
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_has_payload,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_last,
  output logic [2:0] out_event_res,
  output logic [3:0] out_frame_opcode
);

  wsd_pkg::in_word_t in_word;
  wsd_pkg::in_word_t stage_word;
  wsd_pkg::result_t  res;
  wsd_pkg::result_t  res_r;
  logic              stage_valid;
  logic              advance;
  logic              emit;
  logic              out_valid_r;
  logic              out_valid_nxt;

  assign in_word.data_byte     = in_data_byte;
  assign in_word.end_of_buffer = in_end_of_buffer;

  assign advance = stage_valid && (!out_valid_r || out_ready);

  wsd_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_word  (stage_word)
  );

  wsd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .word  (stage_word),
    .emit  (emit),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_payload  = res_r.has_payload;
  assign out_payload_byte = res_r.payload_byte;
  assign out_payload_last = res_r.payload_last;
  assign out_event_res    = res_r.event_res;
  assign out_frame_opcode = res_r.frame_opcode;

  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_payload || out_event_res != wsd_pkg::EV_NONE))
    else $error("result word carries neither payload nor event");

  a_last_needs_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_last) |-> out_has_payload)
    else $error("last marker without payload byte");

  a_event_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_res <= wsd_pkg::EV_UNHAND))
    else $error("event code out of range");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stage_valid && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

@@ src/wsd_in_stage.sv @@
// Input register of the deframer: holds one received word until the parser takes it.
// Depends on wsd_pkg for the word type.
module wsd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wsd_pkg::in_word_t in_word,
  input  logic             advance,
  output logic             stage_valid,
  output wsd_pkg::in_word_t stage_word
);

  logic              valid_r;
  logic              valid_nxt;
  wsd_pkg::in_word_t word_r;
  logic              take;

  assign in_ready    = !valid_r || advance;
  assign take        = in_valid && in_ready;
  assign stage_valid = valid_r;
  assign stage_word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= in_word;
    end
  end

endmodule

@@ src/wsd_parser.sv @@
// Frame parser: header, extended length and mask key state, and payload unmasking.
// Depends on wsd_pkg for opcodes, event codes and the result type.
module wsd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  wsd_pkg::in_word_t word,
  output logic              emit,
  output wsd_pkg::result_t  res
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [63:0] decl_len_r, decl_len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [2:0]  key_left_r, key_left_nxt;
  logic [63:0] count_r, count_nxt;

  logic        len_done;
  logic        hdr_done;
  logic [2:0]  ev;
  logic        has;
  logic [7:0]  pbyte;
  logic        plast;
  logic [7:0]  key_byte;
  logic [7:0]  b;

  assign b = word.data_byte;

  always_comb begin
    case (count_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    opcode_nxt   = opcode_r;
    masked_nxt   = masked_r;
    ext_left_nxt = ext_left_r;
    decl_len_nxt = decl_len_r;
    key_nxt      = key_r;
    key_left_nxt = key_left_r;
    count_nxt    = count_r;
    len_done     = 1'b0;
    hdr_done     = 1'b0;
    ev           = wsd_pkg::EV_NONE;
    has          = 1'b0;
    pbyte        = 8'd0;
    plast        = 1'b0;

    case (phase_r)
      PH_HDR0: begin
        opcode_nxt   = b[3:0];
        masked_nxt   = 1'b0;
        decl_len_nxt = 64'd0;
        key_nxt      = 32'd0;
        ext_left_nxt = 4'd0;
        key_left_nxt = 3'd0;
        count_nxt    = 64'd0;
        phase_nxt    = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = b[7];
        if (b[6:0] < wsd_pkg::LEN16_CODE) begin
          decl_len_nxt = {57'd0, b[6:0]};
          len_done     = 1'b1;
        end else begin
          decl_len_nxt = 64'd0;
          ext_left_nxt = (b[6:0] == wsd_pkg::LEN16_CODE) ? 4'd2 : 4'd8;
          phase_nxt    = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        decl_len_nxt = {decl_len_r[55:0], b};
        ext_left_nxt = ext_left_r - 4'd1;
        len_done     = (ext_left_nxt == 4'd0);
      end
      PH_KEY: begin
        key_nxt      = {key_r[23:0], b};
        key_left_nxt = key_left_r - 3'd1;
        hdr_done     = (key_left_nxt == 3'd0);
      end
      PH_PAYLOAD: begin
        has   = 1'b1;
        pbyte = masked_r ? (b ^ key_byte) : b;
        if (count_r + 64'd1 == decl_len_r) begin
          plast     = 1'b1;
          phase_nxt = PH_SKIP;
        end
        count_nxt = count_r + 64'd1;
      end
      default: begin
      end
    endcase

    if (len_done) begin
      if (masked_nxt) begin
        key_left_nxt = 3'd4;
        phase_nxt    = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      case (opcode_r)
        wsd_pkg::OP_PING: begin
          phase_nxt = PH_SKIP;
          ev        = wsd_pkg::EV_PING;
        end
        wsd_pkg::OP_CLOSE: begin
          phase_nxt = PH_SKIP;
          ev        = wsd_pkg::EV_CLOSE;
        end
        wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY: begin
          count_nxt = 64'd0;
          phase_nxt = (decl_len_nxt != 64'd0) ? PH_PAYLOAD : PH_SKIP;
        end
        default: begin
          phase_nxt = PH_SKIP;
          ev        = wsd_pkg::EV_UNHAND;
        end
      endcase
    end

    if (word.end_of_buffer) begin
      if (phase_nxt == PH_HDR1 || phase_nxt == PH_EXTLEN || phase_nxt == PH_KEY) begin
        ev = wsd_pkg::EV_SHORT;
      end else if (phase_nxt == PH_PAYLOAD) begin
        ev = wsd_pkg::EV_TRUNC;
      end
      phase_nxt = PH_HDR0;
    end
  end

  assign emit             = has || (ev != wsd_pkg::EV_NONE);
  assign res.has_payload  = has;
  assign res.payload_byte = pbyte;
  assign res.payload_last = plast;
  assign res.event_res    = ev;
  assign res.frame_opcode = opcode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      opcode_r   <= 4'd0;
      masked_r   <= 1'b0;
      ext_left_r <= 4'd0;
      decl_len_r <= 64'd0;
      key_r      <= 32'd0;
      key_left_r <= 3'd0;
      count_r    <= 64'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      masked_r   <= masked_nxt;
      ext_left_r <= ext_left_nxt;
      decl_len_r <= decl_len_nxt;
      key_r      <= key_nxt;
      key_left_r <= key_left_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

@@ tb/websocket_frame_deframer_tb.sv @@
// Self-checking testbench for websocket_frame_deframer: directed frames, then random frames,
// broken frames and noise, each output word checked against a behavioural predictor.
// Depends on wsd_pkg and the RTL under src.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1200;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD,
    PH_SKIP
  } parse_phase_t;

  class deframe_scoreboard;
    parse_phase_t     phase;
    logic [3:0]       opcode;
    logic             masked;
    logic [3:0]       ext_left;
    logic [63:0]      decl_len;
    logic [31:0]      key;
    logic [2:0]       key_left;
    logic [63:0]      pay_cnt;
    wsd_pkg::result_t predicted_words[$];
    int               errors;

    function new();
      phase    = PH_HDR0;
      opcode   = '0;
      masked   = 1'b0;
      ext_left = '0;
      decl_len = '0;
      key      = '0;
      key_left = '0;
      pay_cnt  = '0;
      errors   = 0;
    endfunction

    function int pending();
      return predicted_words.size();
    endfunction

    function wsd_pkg::event_t header_done();
      if (opcode == wsd_pkg::OP_PING) begin
        phase = PH_SKIP;
        return wsd_pkg::EV_PING;
      end
      if (opcode == wsd_pkg::OP_CLOSE) begin
        phase = PH_SKIP;
        return wsd_pkg::EV_CLOSE;
      end
      if (opcode == wsd_pkg::OP_TEXT || opcode == wsd_pkg::OP_BINARY) begin
        pay_cnt = '0;
        phase = (decl_len != 0) ? PH_PAYLOAD : PH_SKIP;
        return wsd_pkg::EV_NONE;
      end
      phase = PH_SKIP;
      return wsd_pkg::EV_UNHAND;
    endfunction

    function wsd_pkg::event_t length_done();
      if (masked) begin
        key_left = 3'd4;
        phase = PH_KEY;
        return wsd_pkg::EV_NONE;
      end
      return header_done();
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
      wsd_pkg::event_t  ev;
      logic             has;
      logic             last;
      logic [7:0]       pb;
      logic [7:0]       k;
      wsd_pkg::result_t r;
      ev   = wsd_pkg::EV_NONE;
      has  = 1'b0;
      last = 1'b0;
      pb   = '0;
      k    = '0;
      case (phase)
        PH_HDR0: begin
          opcode   = b[3:0];
          masked   = 1'b0;
          decl_len = '0;
          key      = '0;
          ext_left = '0;
          key_left = '0;
          pay_cnt  = '0;
          phase    = PH_HDR1;
        end
        PH_HDR1: begin
          masked   = b[7];
          decl_len = '0;
          if (b[6:0] < wsd_pkg::LEN16_CODE) begin
            decl_len = 64'(b[6:0]);
            ev = length_done();
          end else begin
            ext_left = (b[6:0] == wsd_pkg::LEN16_CODE) ? 4'd2 : 4'd8;
            phase = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          decl_len = {decl_len[55:0], b};
          ext_left = ext_left - 4'd1;
          if (ext_left == 0) ev = length_done();
        end
        PH_KEY: begin
          key = {key[23:0], b};
          key_left = key_left - 3'd1;
          if (key_left == 0) ev = header_done();
        end
        PH_PAYLOAD: begin
          if (masked) k = key[(3 - int'(pay_cnt[1:0])) * 8 +: 8];
          has = 1'b1;
          pb  = b ^ k;
          if (pay_cnt + 64'd1 == decl_len) begin
            last  = 1'b1;
            phase = PH_SKIP;
          end
          pay_cnt = pay_cnt + 64'd1;
        end
        default: ;
      endcase
      if (eob) begin
        if (phase == PH_HDR1 || phase == PH_EXTLEN || phase == PH_KEY)
          ev = wsd_pkg::EV_SHORT;
        else if (phase == PH_PAYLOAD)
          ev = wsd_pkg::EV_TRUNC;
        phase = PH_HDR0;
      end
      if (has || ev != wsd_pkg::EV_NONE) begin
        r.has_payload  = has;
        r.payload_byte = pb;
        r.payload_last = last;
        r.event_res    = ev;
        r.frame_opcode = opcode;
        predicted_words.push_back(r);
      end
    endfunction

    function void check_word(wsd_pkg::result_t got);
      wsd_pkg::result_t want;
      if (predicted_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: has=%0d byte=%02h last=%0d ev=%0d op=%0d",
                   got.has_payload, got.payload_byte, got.payload_last,
                   got.event_res, got.frame_opcode);
        return;
      end
      want = predicted_words.pop_front();
      if (got.has_payload !== want.has_payload || got.payload_byte !== want.payload_byte ||
          got.payload_last !== want.payload_last || got.event_res !== want.event_res ||
          got.frame_opcode !== want.frame_opcode) begin
        errors++;
        if (errors <= 10) begin
          $display("word mismatch: expected has=%0d byte=%02h last=%0d ev=%0d op=%0d",
                   want.has_payload, want.payload_byte, want.payload_last,
                   want.event_res, want.frame_opcode);
          $display("               got      has=%0d byte=%02h last=%0d ev=%0d op=%0d",
                   got.has_payload, got.payload_byte, got.payload_last,
                   got.event_res, got.frame_opcode);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_end_of_buffer;
  logic       out_valid;
  logic       out_ready;
  logic       out_has_payload;
  logic [7:0] out_payload_byte;
  logic       out_payload_last;
  logic [2:0] out_event_res;
  logic [3:0] out_frame_opcode;

  deframe_scoreboard sb;
  bit quiet;
  int items_sent;
  int stall_cycles;

  websocket_frame_deframer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_has_payload  (out_has_payload),
    .out_payload_byte (out_payload_byte),
    .out_payload_last (out_payload_last),
    .out_event_res    (out_event_res),
    .out_frame_opcode (out_frame_opcode)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    wsd_pkg::result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.has_payload  = out_has_payload;
        got.payload_byte = out_payload_byte;
        got.payload_last = out_payload_last;
        got.event_res    = out_event_res;
        got.frame_opcode = out_frame_opcode;
        sb.check_word(got);
      end
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_end_of_buffer);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic eob);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] bytes[$], input int counted);
    foreach (bytes[i]) push_word(bytes[i], i == bytes.size() - 1);
    items_sent += counted;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_random_frame();
    logic [7:0]  frame[$];
    logic [3:0]  op;
    logic        msk;
    logic [63:0] dlen;
    logic [6:0]  len7;
    int          pick;
    int          hdr;
    int          n;
    int          counted;
    pick = $urandom_range(99);
    if (pick < 40) op = wsd_pkg::OP_TEXT;
    else if (pick < 80) op = wsd_pkg::OP_BINARY;
    else if (pick < 87) op = wsd_pkg::OP_PING;
    else if (pick < 93) op = wsd_pkg::OP_CLOSE;
    else op = 4'($urandom_range(15));
    frame.push_back({4'($urandom_range(15)), op});
    msk = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 70) begin
      dlen = 64'($urandom_range(30));
      len7 = dlen[6:0];
    end else if (pick < 80) begin
      dlen = 64'($urandom_range(125, 31));
      len7 = dlen[6:0];
    end else if (pick < 92) begin
      if ($urandom_range(3) == 0) dlen = 64'($urandom_range(65535));
      else dlen = 64'($urandom_range(40));
      len7 = wsd_pkg::LEN16_CODE;
    end else begin
      if ($urandom_range(1) == 1) dlen = {$urandom, $urandom};
      else dlen = 64'($urandom_range(40));
      len7 = 7'd127;
    end
    frame.push_back({msk, len7});
    if (len7 == wsd_pkg::LEN16_CODE) begin
      frame.push_back(dlen[15:8]);
      frame.push_back(dlen[7:0]);
    end else if (len7 == 7'd127) begin
      for (int i = 7; i >= 0; i--) frame.push_back(dlen[8*i +: 8]);
    end
    if (msk) repeat (4) frame.push_back(8'($urandom));
    hdr = frame.size();
    if ($urandom_range(99) < 8) begin
      frame = frame[0:$urandom_range(hdr - 2)];
    end else begin
      if (dlen > 64'd200) begin
        n = $urandom_range(20, 1);
      end else begin
        pick = $urandom_range(99);
        if (pick < 75 || dlen == 0) n = int'(dlen);
        else if (pick < 87) n = $urandom_range(int'(dlen) - 1);
        else n = int'(dlen) + $urandom_range(4, 1);
      end
      repeat (n) frame.push_back(8'($urandom));
    end
    counted = frame.size();
    send_frame(frame, counted);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      push_word(8'($urandom), (i == n - 1) || ($urandom_range(99) < 30));
    end
    items_sent += n;
  endtask

  initial begin
    logic [7:0] frame[$];
    bit         paused;
    sb               = new();
    quiet            = 1'b0;
    paused           = 1'b0;
    items_sent       = 0;
    stall_cycles     = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data_byte     = '0;
    in_end_of_buffer = 1'b0;
    out_ready        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    frame = '{8'h81, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00};
    send_frame(frame, frame.size());
    frame = '{8'h82, 8'h01, 8'hFF};
    send_frame(frame, frame.size());
    frame = '{8'h89, 8'h00};
    send_frame(frame, frame.size());
    frame = '{8'h88, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04};
    send_frame(frame, frame.size());
    frame = '{8'h80, 8'h00};
    send_frame(frame, frame.size());
    frame = '{8'h81, 8'h00, 8'h55};
    send_frame(frame, frame.size());
    frame = '{8'h82, 8'hFE};
    send_frame(frame, frame.size());
    frame = '{8'h82, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h33};
    send_frame(frame, frame.size());

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      quiet = (items_sent >= 300 && items_sent < 450);
      if ($urandom_range(99) < 85) send_random_frame();
      else send_noise();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/wsd_pkg.sv
src/wsd_in_stage.sv
src/wsd_parser.sv
src/websocket_frame_deframer.sv
tb/websocket_frame_deframer_tb.sv
